[rtl/grmq_pkg.sv]
// Shared types, codes and the sequencer program for the grid occupancy block.
// Used by grmq_rows and grid_rectangle_mark_and_query_top; depends on nothing.
`default_nettype none

package grmq_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BEYOND   = 2'd1;
   localparam logic [1:0] STATUS_REVERSED = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_LOW_BOUND  = 2'd0;
   localparam logic [1:0] CSR_HIGH_BOUND = 2'd1;
   localparam logic [1:0] CSR_CELL_SCALE = 2'd2;

   // Request kinds
   localparam logic KIND_MARK  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Jump conditions of a control word
   localparam logic [2:0] COND_NEXT      = 3'd0;
   localparam logic [2:0] COND_ALWAYS    = 3'd1;
   localparam logic [2:0] COND_NO_START  = 3'd2;
   localparam logic [2:0] COND_ERROR     = 3'd3;
   localparam logic [2:0] COND_MORE_ROWS = 3'd4;

   // Coordinate slots: 0 first_low, 1 first_high, 2 second_low, 3 second_high
   localparam logic [1:0] SLOT_FIRST_LOW   = 2'd0;
   localparam logic [1:0] SLOT_FIRST_HIGH  = 2'd1;
   localparam logic [1:0] SLOT_SECOND_LOW  = 2'd2;
   localparam logic [1:0] SLOT_SECOND_HIGH = 2'd3;

   // Program steps
   localparam logic [3:0] STEP_IDLE  = 4'd0;
   localparam logic [3:0] STEP_Q0    = 4'd1;
   localparam logic [3:0] STEP_Q1    = 4'd2;
   localparam logic [3:0] STEP_Q2    = 4'd3;
   localparam logic [3:0] STEP_Q3    = 4'd4;
   localparam logic [3:0] STEP_Q4    = 4'd5;
   localparam logic [3:0] STEP_Q5    = 4'd6;
   localparam logic [3:0] STEP_CHECK = 4'd7;
   localparam logic [3:0] STEP_LOOP  = 4'd8;
   localparam logic [3:0] STEP_DRAIN = 4'd9;
   localparam logic [3:0] STEP_DONE  = 4'd10;

   typedef struct packed {
      logic [2:0] cond;
      logic [3:0] target;
      logic       sub_en;
      logic [1:0] sub_sel;
      logic       mul_en;
      logic       cell_en;
      logic [1:0] cell_sel;
      logic       check;
      logic       row_rd;
      logic       emit;
   } uword_type;

   // Control between the sequencer and the row store
   typedef struct packed {
      logic rd_en;
      logic query;
   } row_cmd_type;

   function automatic uword_type make_uword(
      input logic [2:0] cond,
      input logic [3:0] target,
      input logic       sub_en,
      input logic [1:0] sub_sel,
      input logic       mul_en,
      input logic       cell_en,
      input logic [1:0] cell_sel,
      input logic       check,
      input logic       row_rd,
      input logic       emit
   );
      uword_type w;
      w.cond     = cond;
      w.target   = target;
      w.sub_en   = sub_en;
      w.sub_sel  = sub_sel;
      w.mul_en   = mul_en;
      w.cell_en  = cell_en;
      w.cell_sel = cell_sel;
      w.check    = check;
      w.row_rd   = row_rd;
      w.emit     = emit;
      return w;
   endfunction

   // Control store: subtract, multiply and clamp overlap across the four slots, then check, walk the rows and emit
   function automatic uword_type urom(input logic [3:0] step);
      uword_type w;
      unique case (step)
         STEP_IDLE:  w = make_uword(COND_NO_START, STEP_IDLE, 1'b0, SLOT_FIRST_LOW,
                                    1'b0, 1'b0, SLOT_FIRST_LOW, 1'b0, 1'b0, 1'b0);
         STEP_Q0:    w = make_uword(COND_NEXT, STEP_IDLE, 1'b1, SLOT_FIRST_LOW,
                                    1'b0, 1'b0, SLOT_FIRST_LOW, 1'b0, 1'b0, 1'b0);
         STEP_Q1:    w = make_uword(COND_NEXT, STEP_IDLE, 1'b1, SLOT_FIRST_HIGH,
                                    1'b1, 1'b0, SLOT_FIRST_LOW, 1'b0, 1'b0, 1'b0);
         STEP_Q2:    w = make_uword(COND_NEXT, STEP_IDLE, 1'b1, SLOT_SECOND_LOW,
                                    1'b1, 1'b1, SLOT_FIRST_LOW, 1'b0, 1'b0, 1'b0);
         STEP_Q3:    w = make_uword(COND_NEXT, STEP_IDLE, 1'b1, SLOT_SECOND_HIGH,
                                    1'b1, 1'b1, SLOT_FIRST_HIGH, 1'b0, 1'b0, 1'b0);
         STEP_Q4:    w = make_uword(COND_NEXT, STEP_IDLE, 1'b0, SLOT_FIRST_LOW,
                                    1'b1, 1'b1, SLOT_SECOND_LOW, 1'b0, 1'b0, 1'b0);
         STEP_Q5:    w = make_uword(COND_NEXT, STEP_IDLE, 1'b0, SLOT_FIRST_LOW,
                                    1'b0, 1'b1, SLOT_SECOND_HIGH, 1'b0, 1'b0, 1'b0);
         STEP_CHECK: w = make_uword(COND_ERROR, STEP_DONE, 1'b0, SLOT_FIRST_LOW,
                                    1'b0, 1'b0, SLOT_FIRST_LOW, 1'b1, 1'b0, 1'b0);
         STEP_LOOP:  w = make_uword(COND_MORE_ROWS, STEP_LOOP, 1'b0, SLOT_FIRST_LOW,
                                    1'b0, 1'b0, SLOT_FIRST_LOW, 1'b0, 1'b1, 1'b0);
         STEP_DRAIN: w = make_uword(COND_NEXT, STEP_IDLE, 1'b0, SLOT_FIRST_LOW,
                                    1'b0, 1'b0, SLOT_FIRST_LOW, 1'b0, 1'b0, 1'b0);
         STEP_DONE:  w = make_uword(COND_ALWAYS, STEP_IDLE, 1'b0, SLOT_FIRST_LOW,
                                    1'b0, 1'b0, SLOT_FIRST_LOW, 1'b0, 1'b0, 1'b1);
         default:    w = make_uword(COND_ALWAYS, STEP_IDLE, 1'b0, SLOT_FIRST_LOW,
                                    1'b0, 1'b0, SLOT_FIRST_LOW, 1'b0, 1'b0, 1'b0);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[rtl/grid_rectangle_mark_and_query_top.sv]
// Rectangle mark/query on a square occupancy bitmap, run by a microcoded
// sequencer. Depends on grmq_pkg and grmq_rows.
// The row loop reads one bitmap row per cycle; a new request is accepted only
// while the sequencer is idle, and the result strobe has no receiver stall.
// Reset clears the bitmap, restores the register defaults and idles the sequencer.
`default_nettype none

module grid_rectangle_mark_and_query_top #(
   parameter int GRID_SIDE = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_kind,
   input  wire logic [31:0] req_first_low,
   input  wire logic [31:0] req_first_high,
   input  wire logic [31:0] req_second_low,
   input  wire logic [31:0] req_second_high,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import grmq_pkg::*;

   localparam int IDX_W = $clog2(GRID_SIDE);

   // Configuration registers
   logic signed [31:0] low_bound_ff;
   logic signed [31:0] high_bound_ff;
   logic [31:0]        cell_scale_ff;

   // Sequencer
   logic [3:0]  step_ff;
   logic [3:0]  step_in;
   uword_type   uw;
   logic        cond_true;

   // Request capture
   logic               kind_ff;
   logic signed [31:0] coord_ff [4];

   // Quantization datapath
   logic signed [31:0] coord_sel;
   logic [31:0]        diff_ff;
   logic               le_ff;
   logic               ge_ff;
   logic [63:0]        prod_ff;
   logic               le2_ff;
   logic               ge2_ff;
   logic [31:0]        quot;
   logic [IDX_W-1:0]   cell_in;
   logic               beyond_in;
   logic [IDX_W-1:0]   cell_ff [4];
   logic               beyond_ff [4];

   // Checks and row loop
   logic [1:0]           status_in;
   logic [1:0]           status_ff;
   logic [GRID_SIDE-1:0] mask_in;
   logic [GRID_SIDE-1:0] mask_ff;
   logic [IDX_W-1:0]     row_ff;
   logic                 last_row;
   logic                 hit_ff;
   logic                 row_hit;
   row_cmd_type          row_cmd;

   // Result
   logic       rsp_valid_ff;
   logic       rsp_hit_ff;
   logic [1:0] rsp_status_ff;

   assign busy       = (step_ff != STEP_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_status = rsp_status_ff;

   assign uw = urom(step_ff);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_bound_ff  <= 32'sd0;
         high_bound_ff <= 32'sd65536;
         cell_scale_ff <= 32'd4194304;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOW_BOUND:  low_bound_ff  <= csr_data;
            CSR_HIGH_BOUND: high_bound_ff <= csr_data;
            CSR_CELL_SCALE: cell_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Evaluate the jump condition
   assign last_row = (row_ff == cell_ff[SLOT_FIRST_HIGH]);
   always_comb begin
      unique case (uw.cond)
         COND_NEXT:      cond_true = 1'b0;
         COND_ALWAYS:    cond_true = 1'b1;
         COND_NO_START:  cond_true = !start;
         COND_ERROR:     cond_true = (status_in != STATUS_OK);
         COND_MORE_ROWS: cond_true = !last_row;
         default:        cond_true = 1'b1;
      endcase
      step_in = cond_true ? uw.target : 4'(step_ff + 4'd1);
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         kind_ff                    <= req_kind;
         coord_ff[SLOT_FIRST_LOW]   <= req_first_low;
         coord_ff[SLOT_FIRST_HIGH]  <= req_first_high;
         coord_ff[SLOT_SECOND_LOW]  <= req_second_low;
         coord_ff[SLOT_SECOND_HIGH] <= req_second_high;
      end
   end

   // Subtract the low edge and compare against both edges
   assign coord_sel = coord_ff[uw.sub_sel];
   always_ff @(posedge clock) begin
      if (uw.sub_en) begin
         diff_ff <= 32'(coord_sel - low_bound_ff);
         le_ff   <= (coord_sel <= low_bound_ff);
         ge_ff   <= (coord_sel >= high_bound_ff);
      end
   end

   // Scale the difference
   always_ff @(posedge clock) begin
      if (uw.mul_en) begin
         prod_ff <= 64'(diff_ff) * 64'(cell_scale_ff);
         le2_ff  <= le_ff;
         ge2_ff  <= ge_ff;
      end
   end

   // Clamp to a cell and flag one beyond the grid
   assign quot = prod_ff[63:32];
   always_comb begin
      if (le2_ff) begin
         cell_in   = '0;
         beyond_in = 1'b0;
      end else if (ge2_ff) begin
         cell_in   = IDX_W'(GRID_SIDE - 1);
         beyond_in = 1'b0;
      end else begin
         cell_in   = quot[IDX_W-1:0];
         beyond_in = (quot >= 32'(GRID_SIDE));
      end
   end

   always_ff @(posedge clock) begin
      if (uw.cell_en) begin
         cell_ff[uw.cell_sel]   <= cell_in;
         beyond_ff[uw.cell_sel] <= beyond_in;
      end
   end

   // Check dimension one, then dimension two
   always_comb begin
      if (beyond_ff[SLOT_FIRST_LOW] || beyond_ff[SLOT_FIRST_HIGH]) begin
         status_in = STATUS_BEYOND;
      end else if (cell_ff[SLOT_FIRST_LOW] > cell_ff[SLOT_FIRST_HIGH]) begin
         status_in = STATUS_REVERSED;
      end else if (beyond_ff[SLOT_SECOND_LOW] || beyond_ff[SLOT_SECOND_HIGH]) begin
         status_in = STATUS_BEYOND;
      end else if (cell_ff[SLOT_SECOND_LOW] > cell_ff[SLOT_SECOND_HIGH]) begin
         status_in = STATUS_REVERSED;
      end else begin
         status_in = STATUS_OK;
      end
   end

   // Build the column mask
   always_comb begin
      for (int c = 0; c < GRID_SIDE; c++) begin
         mask_in[c] = (IDX_W'(c) >= cell_ff[SLOT_SECOND_LOW]) &&
                      (IDX_W'(c) <= cell_ff[SLOT_SECOND_HIGH]);
      end
   end

   // Latch status and mask, then walk the rows
   always_ff @(posedge clock) begin
      if (uw.check) begin
         status_ff <= status_in;
         mask_ff   <= mask_in;
         row_ff    <= cell_ff[SLOT_FIRST_LOW];
      end else if (uw.row_rd && !last_row) begin
         row_ff <= IDX_W'(row_ff + 1'b1);
      end
   end

   // Collect hits over the row loop
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         hit_ff <= 1'b0;
      end else if (row_hit) begin
         hit_ff <= 1'b1;
      end
   end

   assign row_cmd.rd_en = uw.row_rd;
   assign row_cmd.query = kind_ff;

   grmq_rows #(
      .GRID_SIDE (GRID_SIDE)
   ) u_rows (
      .clock   (clock),
      .reset   (reset),
      .cmd     (row_cmd),
      .addr    (row_ff),
      .mask    (mask_ff),
      .row_hit (row_hit)
   );

   // Drive the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= uw.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (uw.emit) begin
         rsp_status_ff <= status_ff;
         rsp_hit_ff    <= (status_ff == STATUS_OK) && hit_ff;
      end
   end

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_error_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> !rsp_hit)
      else $error("hit reported with an error status");

   a_mark_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (kind_ff == KIND_MARK)) |-> !rsp_hit)
      else $error("hit reported for a mark");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("sequencer did not leave idle after accept");
`endif

endmodule

`default_nettype wire

[rtl/grmq_rows.sv]
// Occupancy row store: one row memory with per-row valid bits and a
// read-modify-write / test stage. Depends on grmq_pkg.
`default_nettype none

module grmq_rows #(
   parameter int GRID_SIDE = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire grmq_pkg::row_cmd_type        cmd,
   input  wire logic [$clog2(GRID_SIDE)-1:0] addr,
   input  wire logic [GRID_SIDE-1:0]         mask,
   output logic                              row_hit
);
   import grmq_pkg::*;

   localparam int IDX_W = $clog2(GRID_SIDE);

   logic [GRID_SIDE-1:0] mem [GRID_SIDE];
   logic [GRID_SIDE-1:0] valid_ff;
   logic [GRID_SIDE-1:0] rdata_ff;
   logic                 rvalid_ff;
   logic                 pend_ff;
   logic                 pquery_ff;
   logic [IDX_W-1:0]     paddr_ff;
   logic [GRID_SIDE-1:0] row_cur;
   logic                 wr_en;
   logic [GRID_SIDE-1:0] wr_data;

   // A row never written reads as cleared
   assign row_cur = rvalid_ff ? rdata_ff : '0;
   assign wr_en   = pend_ff && (pquery_ff == KIND_MARK);
   assign wr_data = row_cur | mask;
   assign row_hit = pend_ff && (pquery_ff == KIND_QUERY) && (|(row_cur & mask));

   // Read one row, write back the previous one
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[addr];
      end
      if (wr_en) begin
         mem[paddr_ff] <= wr_data;
      end
   end

   // Track the row in flight
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rvalid_ff <= valid_ff[addr];
         paddr_ff  <= addr;
         pquery_ff <= cmd.query;
      end
   end

   // Hold valid bits and the pending flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= cmd.rd_en;
         if (wr_en) begin
            valid_ff[paddr_ff] <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[tb/grid_rectangle_mark_and_query_checker.sv]
// Scoreboard for the grid occupancy block: keeps its own bitmap and register
// copies, predicts the answer of every accepted request and checks each response.
// Depends on grmq_pkg.
module grid_rectangle_mark_and_query_checker #(
   parameter int GRID_SIDE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_first_low,
   input  logic [31:0] req_first_high,
   input  logic [31:0] req_second_low,
   input  logic [31:0] req_second_high,
   input  logic        rsp_valid,
   input  logic        rsp_hit,
   input  logic [1:0]  rsp_status,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          pending_answers,
   output int          mismatch_count
);
   import grmq_pkg::*;

   typedef struct packed {
      logic       hit;
      logic [1:0] status;
   } grid_answer_type;

   logic [63:0]     occupied [GRID_SIDE];
   logic [31:0]     bound_low;
   logic [31:0]     bound_high;
   logic [31:0]     scale;
   grid_answer_type answers_due [$];
   grid_answer_type due;

   // Map one Q16.16 coordinate to a cell; the result may lie beyond the grid
   function automatic logic [31:0] cell_of(input logic [31:0] coord);
      longint      x;
      longint      lo;
      longint      hi;
      logic [63:0] offset;
      logic [63:0] product;
      x  = longint'($signed(coord));
      lo = longint'($signed(bound_low));
      hi = longint'($signed(bound_high));
      if (x <= lo) return '0;
      if (x >= hi) return 32'(GRID_SIDE - 1);
      offset  = 64'(x - lo);
      product = offset * {32'd0, scale};
      return product[63:32];
   endfunction

   // Flag bad ranges, else mark the covered cells or test them for a set bit
   function automatic grid_answer_type apply_rectangle(
      input logic        kind,
      input logic [31:0] first_low,
      input logic [31:0] first_high,
      input logic [31:0] second_low,
      input logic [31:0] second_high
   );
      logic [31:0]     corner  [4];
      logic [31:0]     lo_cell [2];
      logic [31:0]     hi_cell [2];
      logic [63:0]     columns;
      grid_answer_type answer;
      corner[0] = first_low;
      corner[1] = first_high;
      corner[2] = second_low;
      corner[3] = second_high;
      lo_cell   = '{default: '0};
      hi_cell   = '{default: '0};
      answer.hit    = 1'b0;
      answer.status = STATUS_OK;
      for (int d = 0; d < 2 && answer.status == STATUS_OK; d++) begin
         lo_cell[d] = cell_of(corner[2 * d]);
         hi_cell[d] = cell_of(corner[2 * d + 1]);
         if (lo_cell[d] >= GRID_SIDE || hi_cell[d] >= GRID_SIDE) begin
            answer.status = STATUS_BEYOND;
         end else if (lo_cell[d] > hi_cell[d]) begin
            answer.status = STATUS_REVERSED;
         end
      end
      if (answer.status == STATUS_OK) begin
         columns = '0;
         for (int c = int'(lo_cell[1]); c <= int'(hi_cell[1]); c++) columns[c] = 1'b1;
         for (int r = int'(lo_cell[0]); r <= int'(hi_cell[0]); r++) begin
            if (kind == KIND_QUERY) begin
               if ((occupied[r] & columns) != '0) answer.hit = 1'b1;
            end else begin
               occupied[r] |= columns;
            end
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         // clear the bitmap and restore register defaults
         for (int r = 0; r < GRID_SIDE; r++) occupied[r] = '0;
         bound_low  = 32'h0000_0000;
         bound_high = 32'h0001_0000;
         scale      = 32'h0040_0000;
         answers_due.delete();
         pending_answers <= 0;
      end else begin
         // track register writes; unused indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOW_BOUND:  bound_low  = csr_data;
               CSR_HIGH_BOUND: bound_high = csr_data;
               CSR_CELL_SCALE: scale      = csr_data;
               default: ;
            endcase
         end
         // predict each accepted request
         if (start && !busy) begin
            answers_due.push_back(apply_rectangle(req_kind, req_first_low, req_first_high,
                                                  req_second_low, req_second_high));
         end
         // compare each response with the oldest prediction
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               $display("%0t: response with nothing expected, got hit %0b status %0d",
                        $time, rsp_hit, rsp_status);
               mismatch_count++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_hit !== due.hit) begin
                  $display("%0t: hit mismatch, expected %0b got %0b",
                           $time, due.hit, rsp_hit);
                  mismatch_count++;
               end
               if (rsp_status !== due.status) begin
                  $display("%0t: status mismatch, expected %0d got %0d",
                           $time, due.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         pending_answers <= answers_due.size();
      end
   end

endmodule

[tb/grid_rectangle_mark_and_query_top_tb.sv]
// Testbench top for the grid occupancy block: drives directed and random
// mark/query requests and register writes, and gives the verdict.
// Depends on grmq_pkg, grid_rectangle_mark_and_query_top and the checker.
module grid_rectangle_mark_and_query_top_tb;
   import grmq_pkg::*;

   localparam int         GRID_SIDE    = 64;
   localparam int         STALL_LIMIT  = 2000;
   localparam int         DRAIN_CYCLES = 20;
   localparam logic [1:0] CSR_SPARE    = 2'd3;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        start           = 1'b0;
   logic        req_kind        = KIND_MARK;
   logic [31:0] req_first_low   = '0;
   logic [31:0] req_first_high  = '0;
   logic [31:0] req_second_low  = '0;
   logic [31:0] req_second_high = '0;
   logic        csr_valid       = 1'b0;
   logic [1:0]  csr_index       = CSR_LOW_BOUND;
   logic [31:0] csr_data        = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_hit;
   logic [1:0]  rsp_status;
   logic        csr_ready;
   int          pending_answers;
   int          mismatch_count;
   int          stall_cycles    = 0;
   longint      space_low       = 0;
   longint      space_high      = 65536;
   bit          no_idle         = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   grid_rectangle_mark_and_query_top #(
      .GRID_SIDE(GRID_SIDE)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_first_low  (req_first_low),
      .req_first_high (req_first_high),
      .req_second_low (req_second_low),
      .req_second_high(req_second_high),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   grid_rectangle_mark_and_query_checker #(
      .GRID_SIDE(GRID_SIDE)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_first_low  (req_first_low),
      .req_first_high (req_first_high),
      .req_second_low (req_second_low),
      .req_second_high(req_second_high),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .pending_answers(pending_answers),
      .mismatch_count (mismatch_count)
   );

   // Watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Hold one request on the ports until the block takes it
   task automatic send_request(input logic kind, input logic [31:0] first_low,
                               input logic [31:0] first_high, input logic [31:0] second_low,
                               input logic [31:0] second_high);
      @(negedge clock);
      start           <= 1'b1;
      req_kind        <= kind;
      req_first_low   <= first_low;
      req_first_high  <= first_high;
      req_second_low  <= second_low;
      req_second_high <= second_high;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start for a random gap, mostly short
   task automatic pause_requests();
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 50) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 4);
      else if (pick < 96) gap = $urandom_range(5, 20);
      else gap = $urandom_range(21, 90);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      repeat ($urandom_range(0, 3)) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for the block to go idle, then load a new covered space
   task automatic set_space(input logic [31:0] low, input logic [31:0] high,
                            input logic [31:0] scale, input bit spare);
      @(negedge clock);
      start <= 1'b0;
      while (pending_answers != 0) @(negedge clock);
      write_register(CSR_LOW_BOUND, low);
      write_register(CSR_HIGH_BOUND, high);
      write_register(CSR_CELL_SCALE, scale);
      if (spare) write_register(CSR_SPARE, $urandom());
      space_low  = longint'($signed(low));
      space_high = longint'($signed(high));
   endtask

   function automatic logic [31:0] clip(input longint value);
      if (value > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (value < -64'sd2147483648) return 32'h8000_0000;
      return value[31:0];
   endfunction

   // Coordinate biased toward the covered space and its edges
   function automatic logic [31:0] pick_coord();
      longint lo;
      longint hi;
      longint span;
      int     pick;
      lo   = (space_high > space_low) ? space_low : space_low - 65536;
      hi   = (space_high > space_low) ? space_high : space_low + 65536;
      span = hi - lo + 1;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return clip(space_low);
            default: return clip(space_high);
         endcase
      end
      if (pick < 28) return clip(space_low + longint'($urandom_range(0, 255)));
      return clip(lo + longint'({$urandom(), $urandom()} % 64'(span)));
   endfunction

   // One dimension of a rectangle: mostly narrow and ordered, some reversed or raw
   task automatic pick_range(input logic kind, output logic [31:0] lo, output logic [31:0] hi);
      longint base;
      longint width;
      longint step;
      int     pick;
      pick = $urandom_range(0, 99);
      step = (space_high > space_low) ? (space_high - space_low) / GRID_SIDE : 1024;
      if (pick < 10) begin
         lo = $urandom();
         hi = $urandom();
         // raw marks go in reversed so they do not flood the bitmap
         if (kind == KIND_MARK && $signed(lo) < $signed(hi)) {lo, hi} = {hi, lo};
      end else begin
         base  = longint'($signed(pick_coord()));
         width = step * longint'($urandom_range(0, (kind == KIND_MARK) ? 1 : 12))
                 + longint'($urandom_range(0, 255));
         lo = clip(base);
         hi = clip(base + width);
         if (pick < 22) {lo, hi} = {hi, lo};
      end
   endtask

   task automatic run_random(input logic [31:0] low, input logic [31:0] high,
                             input logic [31:0] scale, input int count);
      logic [31:0] first_low;
      logic [31:0] first_high;
      logic [31:0] second_low;
      logic [31:0] second_high;
      logic        kind;
      set_space(low, high, scale, 1'b0);
      for (int i = 0; i < count; i++) begin
         // every so often run a stretch with no idling
         if (i % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
         kind = ($urandom_range(0, 99) < 40) ? KIND_MARK : KIND_QUERY;
         pick_range(kind, first_low, first_high);
         pick_range(kind, second_low, second_high);
         send_request(kind, first_low, first_high, second_low, second_high);
         pause_requests();
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset space: empty grid, corner and column marks, reversed ranges
      send_request(KIND_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(KIND_MARK, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_request(KIND_MARK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(KIND_MARK, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5127, 32'd5127);
      send_request(KIND_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(KIND_QUERY, 32'd10240, 32'd10240, 32'd20480, 32'd20480);
      send_request(KIND_QUERY, 32'd10240, 32'd10240, 32'd5120, 32'd6143);
      send_request(KIND_MARK, 32'h0001_0000, 32'd0, 32'd0, 32'd100);
      send_request(KIND_QUERY, 32'd0, 32'd100, 32'h0001_0000, 32'd0);
      send_request(KIND_QUERY, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'd0);
      send_request(KIND_QUERY, 32'd2047, 32'd1024, 32'd3000, 32'd2048);

      // huge scale: cells beyond the grid and the order of the checks
      set_space(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_request(KIND_QUERY, 32'd65, 32'd66, 32'd1, 32'd2);
      send_request(KIND_QUERY, 32'd1, 32'd65, 32'd1, 32'd2);
      send_request(KIND_QUERY, 32'd64, 32'd2, 32'd100, 32'd200);
      send_request(KIND_MARK, 32'd1, 32'd2, 32'd100, 32'd10);
      send_request(KIND_MARK, 32'd10, 32'd12, 32'd20, 32'd20);
      send_request(KIND_QUERY, 32'd12, 32'd12, 32'd20, 32'd21);

      // zero scale: every interior coordinate lands in cell 0
      set_space(32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, 1'b1);
      send_request(KIND_QUERY, -32'sd5, 32'd5, 32'h0001_0000, 32'h0001_0000);
      send_request(KIND_MARK, 32'd100, 32'h7FFF_FFFF, -32'sd100, 32'd3);
      send_request(KIND_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);

      // high bound below low bound: the low test wins
      set_space(32'h0001_0000, 32'h0000_0000, 32'h0040_0000, 1'b0);
      send_request(KIND_QUERY, 32'h0000_8000, 32'h0002_0000, 32'h0000_8000, 32'h0002_0000);
      send_request(KIND_QUERY, 32'h0002_0000, 32'h0000_8000, 32'h0000_8000, 32'h0002_0000);

      // random requests across several spaces, extremes among them
      run_random(32'hFFFF_0000, 32'h0001_0000, 32'h0020_0000, 110);
      run_random(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0040, 110);
      run_random(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 100);
      run_random(32'hFFF0_0000, 32'h0010_0000, 32'h0000_0000, 60);
      run_random(32'h0003_0000, 32'h0001_0000, 32'h0040_0000, 60);
      run_random($urandom(), $urandom(), $urandom(), 110);
      run_random(32'h0000_0000, 32'h0001_0000, 32'h0040_0000, 200);

      // drain outstanding responses, then watch for strays
      @(negedge clock);
      start <= 1'b0;
      while (pending_answers != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_answers == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
